// ===== sv/grmc_pkg.sv =====
// Shared types, constants and helper functions for the grid ray march column block.
// Used by grmc_div and grid_ray_march_column; depends on nothing else.
package grmc_pkg;

  localparam int SCREEN_WIDTH  = 120;
  localparam int SCREEN_HEIGHT = 40;
  localparam int MAP_SIZE      = 16;
  localparam int DEPTH_TENTHS  = 160;

  // Angle: 4096 units per turn, quarter turn offsets sine to cosine.
  localparam int ANGLE_QUARTER = 1024;
  localparam int ANGLE_DEN     = 2 * SCREEN_WIDTH;
  localparam int ANGLE_BIAS    = 2 * SCREEN_WIDTH * 4096;

  // March position units: 1/163840 map unit = Q4.12 times 40.
  localparam int POS_SCALE  = 40;
  localparam int CELL_SCALE = 163840;
  localparam int MAP_LIMIT  = MAP_SIZE * CELL_SCALE;
  // CELL_SCALE = 5 << CELL_SHIFT; divide by 5 through a reciprocal.
  localparam int CELL_SHIFT  = 15;
  localparam int RECIP5      = 205;
  localparam int RECIP5_SHIFT = 10;

  localparam int ACC_W   = 24;
  localparam int DIST_W  = 8;
  localparam int CEIL_W  = 10;
  localparam int FLOOR_W = 9;
  localparam int SHADE_W = 3;

  // Shared divider sizing.
  localparam int DIV_NUM_W = 22;
  localparam int DIV_DEN_W = 9;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAP0  = 3'd0;
  localparam logic [2:0] CFG_MAP1  = 3'd1;
  localparam logic [2:0] CFG_MAP2  = 3'd2;
  localparam logic [2:0] CFG_MAP3  = 3'd3;
  localparam logic [2:0] CFG_PX    = 3'd4;
  localparam logic [2:0] CFG_PY    = 3'd5;
  localparam logic [2:0] CFG_ANGLE = 3'd6;
  localparam logic [2:0] CFG_FOV   = 3'd7;

  // Shade classes.
  localparam logic [SHADE_W-1:0] SHADE_FULL   = 3'd0;
  localparam logic [SHADE_W-1:0] SHADE_DARK   = 3'd1;
  localparam logic [SHADE_W-1:0] SHADE_MEDIUM = 3'd2;
  localparam logic [SHADE_W-1:0] SHADE_LIGHT  = 3'd3;
  localparam logic [SHADE_W-1:0] SHADE_BLANK  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ADIV,
    ST_SIN,
    ST_COS,
    ST_INIT,
    ST_MARCH,
    ST_CDIV,
    ST_CWAIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  // Quarter-wave sine table, Q2.14, 64 angle units per entry.
  function automatic logic [14:0] qsine(input logic [4:0] idx);
    logic [14:0] v;
    case (idx)
      5'd0:    v = 15'd0;
      5'd1:    v = 15'd1606;
      5'd2:    v = 15'd3196;
      5'd3:    v = 15'd4756;
      5'd4:    v = 15'd6270;
      5'd5:    v = 15'd7723;
      5'd6:    v = 15'd9102;
      5'd7:    v = 15'd10394;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd12665;
      5'd10:   v = 15'd13623;
      5'd11:   v = 15'd14449;
      5'd12:   v = 15'd15137;
      5'd13:   v = 15'd15678;
      5'd14:   v = 15'd16069;
      5'd15:   v = 15'd16305;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // Sine of a 12-bit angle, Q2.14, interpolated and truncated down.
  function automatic logic signed [15:0] sine_q14(input logic [11:0] a);
    logic [1:0]  q;
    logic [10:0] r;
    logic [4:0]  idx;
    logic [5:0]  frac;
    logic [14:0] base;
    logic [14:0] upper;
    logic [16:0] prod;
    logic [14:0] v;
    q = a[11:10];
    r = {1'b0, a[9:0]};
    if (q[0]) begin
      r = 11'(ANGLE_QUARTER) - r;
    end
    idx  = r[10:6];
    frac = r[5:0];
    base  = qsine(idx);
    upper = qsine(5'(idx + 5'd1));
    prod  = 17'(upper - base) * 17'(frac);
    if (idx >= 5'd16) begin
      v = qsine(5'd16);
    end else begin
      v = base + 15'(prod >> 6);
    end
    return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

// ===== sv/grmc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on grmc_pkg for the request and response structs and widths.
module grmc_div import grmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_NUM_W);
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when the divisor fits
      quo_nxt = {quo_r[DIV_NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== sv/grid_ray_march_column.sv =====
// Top level of the grid ray march column block: sequencer, march datapath, config.
// Depends on grmc_pkg and grmc_div.
//
// Usage: write the wall bitmap, player position, heading and field of view on the
// cfg_ channel (index, data, valid/ready; ready is always high) while the block is
// idle. Then send a screen column on the in_ channel; an item is taken when
// in_valid is high and in_stall is low. The block casts that column's ray and
// returns one result item on the out_ channel, taken when out_valid is high and
// out_stall is low.
// Per item the sequencer runs multiply, angle sum, angle division, sine, cosine,
// march setup, march (D steps, 1..160), ceiling division and push, in order. The
// march runs one step a cycle through one accumulator pair; the two divisions
// share one bit-serial divider. in_stall stays high until the item reaches the
// output register. A result waiting under out_stall does not block the next
// item, but a second finished result waits until the first is taken.
// Reset (synchronous, rst_n low) empties the block and loads the register
// defaults: empty map, player at the map center, heading 0, view width 512.
module grid_ray_march_column import grmc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [6:0]                in_column,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [6:0]                out_column_out,
  output logic [DIST_W-1:0]         out_distance_tenths,
  output logic                      out_reached_limit,
  output logic signed [CEIL_W-1:0]  out_ceiling_row,
  output logic [FLOOR_W-1:0]        out_floor_row,
  output logic [SHADE_W-1:0]        out_shade_class
);

  localparam logic signed [ACC_W-1:0] NEG_CELL  = -ACC_W'(CELL_SCALE);
  localparam logic signed [ACC_W-1:0] POS_LIMIT = ACC_W'(MAP_LIMIT);
  localparam int HD_W = 14;

  // configuration
  logic [63:0] map0_r, map1_r, map2_r, map3_r;
  logic [15:0] px_r, py_r;
  logic [11:0] pangle_r, fov_r;
  logic [255:0] wall_map;

  // sequencer and datapath
  state_t                  state_r, state_nxt;
  logic [6:0]              col_r, col_nxt;
  logic [18:0]             prod_r, prod_nxt;
  logic [11:0]             ang_r, ang_nxt;
  logic signed [15:0]      ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [ACC_W-1:0] accx_r, accx_nxt, accy_r, accy_nxt;
  logic [DIST_W-1:0]       d_r, d_nxt;
  logic                    limit_r, limit_nxt;
  logic                    cneg_r, cneg_nxt;
  logic [CEIL_W-1:0]       ceil_r, ceil_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [6:0]              ocol_r, ocol_nxt;
  logic [DIST_W-1:0]       odist_r, odist_nxt;
  logic                    olimit_r, olimit_nxt;
  logic [CEIL_W-1:0]       oceil_r, oceil_nxt;
  logic [FLOOR_W-1:0]      ofloor_r, ofloor_nxt;
  logic [SHADE_W-1:0]      oshade_r, oshade_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [22:0]   num;
  logic [21:0]   pos_x40, pos_y40;
  logic          in_map;
  logic [3:0]    cell_x, cell_y;
  logic          wall_hit;
  logic [HD_W-1:0] hd;
  logic [CEIL_W-1:0] cq;
  logic [9:0]    d4;
  logic [9:0]    d3;
  logic [8:0]    d2;
  logic [SHADE_W-1:0] shade;
  logic          push;

  // Map cell of a march position: negatives round toward zero into cell 0.
  function automatic logic [3:0] cell_of(input logic signed [ACC_W-1:0] acc);
    logic [14:0] p;
    p = 15'(acc[CELL_SHIFT+6:CELL_SHIFT]) * 15'(RECIP5);
    return acc[ACC_W-1] ? 4'd0 : p[RECIP5_SHIFT+3:RECIP5_SHIFT];
  endfunction

  grmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign wall_map  = {map3_r, map2_r, map1_r, map0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map0_r   <= '0;
      map1_r   <= '0;
      map2_r   <= '0;
      map3_r   <= '0;
      px_r     <= 16'h8000;
      py_r     <= 16'h8000;
      pangle_r <= '0;
      fov_r    <= 12'd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAP0:  map0_r   <= cfg_data;
        CFG_MAP1:  map1_r   <= cfg_data;
        CFG_MAP2:  map2_r   <= cfg_data;
        CFG_MAP3:  map3_r   <= cfg_data;
        CFG_PX:    px_r     <= cfg_data[15:0];
        CFG_PY:    py_r     <= cfg_data[15:0];
        CFG_ANGLE: pangle_r <= cfg_data[11:0];
        CFG_FOV:   fov_r    <= cfg_data[11:0];
        default:   map0_r   <= map0_r;
      endcase
    end
  end

  assign num = 23'(pangle_r) * 23'(ANGLE_DEN) + {3'b0, prod_r, 1'b0}
             + 23'(ANGLE_BIAS) - 23'(fov_r) * 23'(SCREEN_WIDTH);
  assign pos_x40 = 22'(px_r) * 22'(POS_SCALE);
  assign pos_y40 = 22'(py_r) * 22'(POS_SCALE);

  assign in_map = (accx_r > NEG_CELL) && (accx_r < POS_LIMIT)
               && (accy_r > NEG_CELL) && (accy_r < POS_LIMIT);
  assign cell_x   = cell_of(accx_r);
  assign cell_y   = cell_of(accy_r);
  assign wall_hit = wall_map[{cell_x, cell_y}];

  assign hd = HD_W'(d_r) * HD_W'(SCREEN_HEIGHT);
  assign cq = div_rsp.quotient[CEIL_W-1:0];

  assign d4 = {d_r, 2'b00};
  assign d3 = 10'(d_r) * 10'd3;
  assign d2 = {d_r, 1'b0};
  always_comb begin
    if (d4 <= 10'(DEPTH_TENTHS)) begin
      shade = SHADE_FULL;
    end else if (d3 < 10'(DEPTH_TENTHS)) begin
      shade = SHADE_DARK;
    end else if (d2 < 9'(DEPTH_TENTHS)) begin
      shade = SHADE_MEDIUM;
    end else if (d_r < DIST_W'(DEPTH_TENTHS)) begin
      shade = SHADE_LIGHT;
    end else begin
      shade = SHADE_BLANK;
    end
  end

  assign push = (state_r == ST_PUSH) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    prod_nxt  = prod_r;
    ang_nxt   = ang_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    d_nxt     = d_r;
    limit_nxt = limit_r;
    cneg_nxt  = cneg_r;
    ceil_nxt  = ceil_r;
    div_req.start    = 1'b0;
    div_req.dividend = num[DIV_NUM_W-1:0];
    div_req.divisor  = DIV_DEN_W'(ANGLE_DEN);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          col_nxt   = in_column;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = 19'(col_r) * 19'(fov_r);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        div_req.start = 1'b1;
        state_nxt     = ST_ADIV;
      end
      ST_ADIV: begin
        if (div_rsp.done) begin
          // keep the angle modulo one turn
          ang_nxt   = div_rsp.quotient[11:0];
          state_nxt = ST_SIN;
        end
      end
      ST_SIN: begin
        ex_nxt    = sine_q14(ang_r);
        state_nxt = ST_COS;
      end
      ST_COS: begin
        ey_nxt    = sine_q14(12'(ang_r + 12'(ANGLE_QUARTER)));
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        accx_nxt  = $signed({2'b00, pos_x40}) + {{(ACC_W-16){ex_r[15]}}, ex_r};
        accy_nxt  = $signed({2'b00, pos_y40}) + {{(ACC_W-16){ey_r[15]}}, ey_r};
        d_nxt     = DIST_W'(1);
        state_nxt = ST_MARCH;
      end
      ST_MARCH: begin
        if (!in_map) begin
          d_nxt     = DIST_W'(DEPTH_TENTHS);
          limit_nxt = 1'b1;
          state_nxt = ST_CDIV;
        end else if (wall_hit) begin
          limit_nxt = 1'b0;
          state_nxt = ST_CDIV;
        end else if (d_r == DIST_W'(DEPTH_TENTHS)) begin
          limit_nxt = 1'b1;
          state_nxt = ST_CDIV;
        end else begin
          // advance one tenth along the ray
          d_nxt    = d_r + DIST_W'(1);
          accx_nxt = accx_r + {{(ACC_W-16){ex_r[15]}}, ex_r};
          accy_nxt = accy_r + {{(ACC_W-16){ey_r[15]}}, ey_r};
        end
      end
      ST_CDIV: begin
        // divide the magnitude of H*d - 20H by 2d, sign applied afterward
        cneg_nxt      = hd < HD_W'(20 * SCREEN_HEIGHT);
        div_req.start = 1'b1;
        div_req.divisor = {d_r, 1'b0};
        if (hd < HD_W'(20 * SCREEN_HEIGHT)) begin
          div_req.dividend = DIV_NUM_W'(HD_W'(20 * SCREEN_HEIGHT) - hd);
        end else begin
          div_req.dividend = DIV_NUM_W'(hd - HD_W'(20 * SCREEN_HEIGHT));
        end
        state_nxt = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (div_rsp.done) begin
          ceil_nxt  = cneg_r ? -cq : cq;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    ocol_nxt   = ocol_r;
    odist_nxt  = odist_r;
    olimit_nxt = olimit_r;
    oceil_nxt  = oceil_r;
    ofloor_nxt = ofloor_r;
    oshade_nxt = oshade_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      ocol_nxt   = col_r;
      odist_nxt  = d_r;
      olimit_nxt = limit_r;
      oceil_nxt  = ceil_r;
      ofloor_nxt = FLOOR_W'(CEIL_W'(SCREEN_HEIGHT) - ceil_r);
      oshade_nxt = shade;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    prod_r   <= prod_nxt;
    ang_r    <= ang_nxt;
    ex_r     <= ex_nxt;
    ey_r     <= ey_nxt;
    accx_r   <= accx_nxt;
    accy_r   <= accy_nxt;
    d_r      <= d_nxt;
    limit_r  <= limit_nxt;
    cneg_r   <= cneg_nxt;
    ceil_r   <= ceil_nxt;
    ocol_r   <= ocol_nxt;
    odist_r  <= odist_nxt;
    olimit_r <= olimit_nxt;
    oceil_r  <= oceil_nxt;
    ofloor_r <= ofloor_nxt;
    oshade_r <= oshade_nxt;
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_column_out      = ocol_r;
  assign out_distance_tenths = odist_r;
  assign out_reached_limit   = olimit_r;
  assign out_ceiling_row     = $signed(oceil_r);
  assign out_floor_row       = ofloor_r;
  assign out_shade_class     = oshade_r;

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_ADIV || state_r == ST_CWAIT))
    else $error("divider finished while the sequencer was not waiting");

  a_march_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MARCH |-> (d_r >= DIST_W'(1) && d_r <= DIST_W'(DEPTH_TENTHS)))
    else $error("march step count out of range");

  a_rows_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CEIL_W'(out_floor_row) + oceil_r == CEIL_W'(SCREEN_HEIGHT)))
    else $error("ceiling and floor rows do not span the screen height");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_MUL && in_stall))
    else $error("accepted item did not start the sequencer");

endmodule
